// ===== sv/rwg_pkg.sv =====
// ----------------------------------------------------------------------------
// rwg_pkg
// Shared codes, widths and types for the read/write grouping controller.
// ----------------------------------------------------------------------------
package rwg_pkg;

  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 64;
  localparam int TIME_W     = 64;
  localparam int MISS_SHIFT = 12;

  localparam logic [2:0] ST_ENQUEUED   = 3'd0;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd1;
  localparam logic [2:0] ST_READ_DONE  = 3'd2;
  localparam logic [2:0] ST_WRITE_DONE = 3'd3;
  localparam logic [2:0] ST_NO_REQUEST = 3'd4;
  localparam logic [2:0] ST_TRANSITION = 3'd5;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TURN  = 2'd2;

  localparam logic IN_ENQUEUE = 1'b0;
  localparam logic IN_SERVICE = 1'b1;

  localparam logic CFG_BURST_LIMIT = 1'b0;
  localparam logic CFG_BANK_BUSY   = 1'b1;

  localparam logic [10:0] COUNT_MAX   = 11'd2047;
  localparam logic [10:0] BURST_RESET = 11'd512;
  localparam logic [15:0] BUSY_RESET  = 16'd100;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== sv/rwg_mod.sv =====
// ----------------------------------------------------------------------------
// rwg_mod
// Remainder of a 32-bit value by a constant through reciprocal
// multiplication: the input, the product and the remainder are registered in turn.
// ----------------------------------------------------------------------------
module rwg_mod #(
  parameter int DIV = 16,
  parameter int RW  = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rwg_pkg::ADDR_W-1:0] value,
  output logic                       done,
  output logic [RW-1:0]              rem
);
  import rwg_pkg::*;

  localparam int                LG    = $clog2(DIV);
  localparam int                SH    = ADDR_W + LG;
  localparam logic [33:0]       M_C   = 34'(((64'd1 << SH) / 64'(DIV)) + 64'd1);
  localparam logic [ADDR_W-1:0] DIV_C = ADDR_W'(DIV);

  logic [ADDR_W-1:0] val_r;
  logic [65:0]       prod_r;
  logic [ADDR_W-1:0] quo;
  logic [ADDR_W-1:0] rem_full;
  logic [RW-1:0]     rem_r;
  logic              s1_r, s2_r, done_r;

  // the reciprocal is rounded up, which keeps the quotient exact for 32 bits
  assign quo      = ADDR_W'(prod_r >> SH);
  assign rem_full = val_r - ADDR_W'(quo * DIV_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      s2_r   <= s1_r;
      done_r <= s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
    end
    if (s1_r) begin
      prod_r <= 66'(val_r) * 66'(M_C);
    end
    if (s2_r) begin
      rem_r <= rem_full[RW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== sv/rwg_queue.sv =====
// ----------------------------------------------------------------------------
// rwg_queue
// Ring queue in a synchronous memory; head entry registered every cycle.
// ----------------------------------------------------------------------------
module rwg_queue #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   rd_data,
  output rwg_pkg::q_status_t status
);
  import rwg_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST     = PW'(DEPTH - 1);
  localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;
  logic [PW-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [OW-1:0]    occ_r, occ_nxt;
  q_status_t        st;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    if (pop) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
    end
    if (push) begin
      tail_nxt = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   occ_nxt = occ_r + 1'b1;
      2'b01:   occ_nxt = occ_r - 1'b1;
      default: occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= push_data;
    end
    rd_data_r <= mem[head_r];
  end

  assign st.empty = (occ_r == '0);
  assign st.full  = (occ_r == FULL_OCC);
  assign status   = st;
  assign rd_data  = rd_data_r;

endmodule

// ===== sv/read_write_grouping_memory_controller.sv =====
// ----------------------------------------------------------------------------
// read_write_grouping_memory_controller
// Read/write grouping controller with ring queues, TLB, bank timers and a
// byte buffer, all held in synchronous memories.
// ----------------------------------------------------------------------------
// One transaction at a time. Enqueue, transition and no-request transactions
// give their result in the cycle after acceptance; a served request passes
// twice through the remainder units (TLB index, then bank and buffer offset)
// and through the single byte port of the buffer, which moves one byte a
// cycle. After reset the block runs a clearing pass, with one index counter up
// to max(BUFFER_BYTES, TLB_ENTRIES) - 1, over the buffer, TLB and bank timers
// before it accepts a transaction; configuration writes are taken throughout.
module read_write_grouping_memory_controller #(
  parameter int QUEUE_DEPTH  = 1024,
  parameter int BANK_COUNT   = 16,
  parameter int TLB_ENTRIES  = 64,
  parameter int BUFFER_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_address,
  input  logic [63:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_read_data,
  output logic [31:0] out_physical_address,
  output logic [3:0]  out_bank_number,
  output logic [63:0] out_start_time,
  output logic        out_tlb_hit,
  output logic [1:0]  out_bus_mode,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import rwg_pkg::*;

  localparam int TW      = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int BKW     = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int BW      = $clog2(BUFFER_BYTES);
  localparam int CLR_LEN = (BUFFER_BYTES > TLB_ENTRIES) ? BUFFER_BYTES : TLB_ENTRIES;
  localparam int CW      = $clog2(CLR_LEN);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_LEN - 1);
  localparam logic [BW-1:0] BUF_LAST = BW'(BUFFER_BYTES - 1);
  localparam logic [CW:0]   BUF_LEN  = (CW+1)'(BUFFER_BYTES);
  localparam logic [CW:0]   TLB_LEN  = (CW+1)'(TLB_ENTRIES);
  localparam logic [CW:0]   BANK_LEN = (CW+1)'(BANK_COUNT);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_TSTART = 4'd2;
  localparam logic [3:0] S_TWAIT  = 4'd3;
  localparam logic [3:0] S_TLOOK  = 4'd4;
  localparam logic [3:0] S_PWAIT  = 4'd5;
  localparam logic [3:0] S_BANKRD = 4'd6;
  localparam logic [3:0] S_BYTE   = 4'd7;
  localparam logic [3:0] S_DRAIN  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  // control state
  logic [3:0]  state_r, state_nxt;
  logic [10:0] burst_limit_r, burst_limit_nxt;
  logic [15:0] busy_time_r, busy_time_nxt;
  logic [1:0]  cur_mode_r, cur_mode_nxt;
  logic        prev_mode_r, prev_mode_nxt;
  logic [10:0] reads_served_r, reads_served_nxt;
  logic [10:0] writes_served_r, writes_served_nxt;
  logic [63:0] step_time_r, step_time_nxt;
  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        rv_r, rv_nxt;
  logic [2:0]  byte_cnt_r, byte_cnt_nxt;

  // payload
  logic        serve_rd_r, serve_rd_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [63:0] wdata_r, wdata_nxt;
  logic        hit_r, hit_nxt;
  logic [31:0] pa_r, pa_nxt;
  logic [63:0] start_r, start_nxt;
  logic [BW-1:0] buf_idx_r, buf_idx_nxt;
  logic [2:0]  lane_r, lane_nxt;
  logic [63:0] rdata_r, rdata_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [63:0] out_read_data_r, out_read_data_nxt;
  logic [31:0] out_pa_r, out_pa_nxt;
  logic [3:0]  out_bank_r, out_bank_nxt;
  logic [63:0] out_start_r, out_start_nxt;
  logic        out_hit_r, out_hit_nxt;
  logic [1:0]  out_bus_mode_r, out_bus_mode_nxt;

  logic        accept;
  logic        rq_push, rq_pop, wq_push, wq_pop;
  logic [31:0] rq_data;
  logic [95:0] wq_data;
  q_status_t   rq_st, wq_st;

  logic          tidx_start, tidx_done, pmod_start, bank_done, base_done;
  logic [TW-1:0] tidx_rem;
  logic [BKW-1:0] bank_rem;
  logic [BW-1:0] base_rem;
  logic [BKW+3:0] bank_ext;
  logic [31:0]   q_addr;

  logic [63:0]   tlb_mem [TLB_ENTRIES];
  logic [63:0]   tlb_q_r;
  logic          tlb_we;
  logic [TW-1:0] tlb_waddr;
  logic [63:0]   tlb_wdata;
  logic          hit_c;
  logic [31:0]   pa_c;

  logic [63:0]    bank_mem [BANK_COUNT];
  logic [63:0]    bank_q_r;
  logic           bank_we;
  logic [BKW-1:0] bank_waddr;
  logic [63:0]    bank_wdata;
  logic [63:0]    start_c;

  logic [7:0]    buf_mem [BUFFER_BYTES];
  logic [7:0]    buf_q_r;
  logic          buf_we;
  logic [BW-1:0] buf_addr;
  logic [7:0]    buf_wdata;

  logic          clearing;
  logic          reading, own_empty, other_busy, sw;
  logic [10:0]   served_inc;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign clearing = (state_r == S_CLEAR);

  rwg_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(32)) u_rq (
    .clk(clk), .rst_n(rst_n), .push(rq_push), .push_data(in_address),
    .pop(rq_pop), .rd_data(rq_data), .status(rq_st)
  );

  rwg_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(96)) u_wq (
    .clk(clk), .rst_n(rst_n), .push(wq_push), .push_data({in_address, in_write_data}),
    .pop(wq_pop), .rd_data(wq_data), .status(wq_st)
  );

  assign q_addr     = serve_rd_r ? rq_data : wq_data[95:64];
  assign tidx_start = (state_r == S_TSTART);
  assign pmod_start = (state_r == S_TLOOK);

  rwg_mod #(.DIV(TLB_ENTRIES), .RW(TW)) u_tidx (
    .clk(clk), .rst_n(rst_n), .start(tidx_start), .value(q_addr),
    .done(tidx_done), .rem(tidx_rem)
  );

  rwg_mod #(.DIV(BANK_COUNT), .RW(BKW)) u_bank (
    .clk(clk), .rst_n(rst_n), .start(pmod_start), .value(pa_c),
    .done(bank_done), .rem(bank_rem)
  );

  rwg_mod #(.DIV(BUFFER_BYTES), .RW(BW)) u_base (
    .clk(clk), .rst_n(rst_n), .start(pmod_start), .value(pa_c),
    .done(base_done), .rem(base_rem)
  );

  assign bank_ext = (BKW+4)'(bank_rem);

  // TLB lookup
  assign hit_c = (tlb_q_r[63:32] == addr_r);
  assign pa_c  = hit_c ? tlb_q_r[31:0] : (addr_r ^ (addr_r >> MISS_SHIFT));

  assign tlb_we    = (clearing && ({1'b0, clr_cnt_r} < TLB_LEN)) ||
                     ((state_r == S_TLOOK) && !hit_c);
  assign tlb_waddr = clearing ? clr_cnt_r[TW-1:0] : tidx_rem;
  assign tlb_wdata = clearing ? 64'd0 : {addr_r, pa_c};

  always_ff @(posedge clk) begin
    if (tlb_we) begin
      tlb_mem[tlb_waddr] <= tlb_wdata;
    end
    tlb_q_r <= tlb_mem[tidx_rem];
  end

  // bank timers
  assign start_c    = (bank_q_r > step_time_r) ? bank_q_r : step_time_r;
  assign bank_we    = (clearing && ({1'b0, clr_cnt_r} < BANK_LEN)) ||
                      (state_r == S_BANKRD);
  assign bank_waddr = clearing ? clr_cnt_r[BKW-1:0] : bank_rem;
  assign bank_wdata = clearing ? 64'd0 : (start_c + {48'd0, busy_time_r});

  always_ff @(posedge clk) begin
    if (bank_we) begin
      bank_mem[bank_waddr] <= bank_wdata;
    end
    bank_q_r <= bank_mem[bank_rem];
  end

  // byte buffer
  assign buf_we    = (clearing && ({1'b0, clr_cnt_r} < BUF_LEN)) ||
                     ((state_r == S_BYTE) && !serve_rd_r);
  assign buf_addr  = clearing ? clr_cnt_r[BW-1:0] : buf_idx_r;
  assign buf_wdata = clearing ? 8'd0 : wdata_r[byte_cnt_r*8 +: 8];

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_addr] <= buf_wdata;
    end
    buf_q_r <= buf_mem[buf_addr];
  end

  // mode decision for a service transaction
  assign reading    = (cur_mode_r == MODE_READ);
  assign own_empty  = reading ? rq_st.empty : wq_st.empty;
  assign other_busy = reading ? !wq_st.empty : !rq_st.empty;
  assign served_inc = reading ?
                      ((reads_served_r < COUNT_MAX) ? reads_served_r + 11'd1 : reads_served_r) :
                      ((writes_served_r < COUNT_MAX) ? writes_served_r + 11'd1 : writes_served_r);

  always_comb begin
    state_nxt         = state_r;
    burst_limit_nxt   = burst_limit_r;
    busy_time_nxt     = busy_time_r;
    cur_mode_nxt      = cur_mode_r;
    prev_mode_nxt     = prev_mode_r;
    reads_served_nxt  = reads_served_r;
    writes_served_nxt = writes_served_r;
    step_time_nxt     = step_time_r;
    clr_cnt_nxt       = clr_cnt_r;
    out_valid_nxt     = out_valid_r && out_stall;
    rv_nxt            = 1'b0;
    byte_cnt_nxt      = byte_cnt_r;
    serve_rd_nxt      = serve_rd_r;
    addr_nxt          = addr_r;
    wdata_nxt         = wdata_r;
    hit_nxt           = hit_r;
    pa_nxt            = pa_r;
    start_nxt         = start_r;
    buf_idx_nxt       = buf_idx_r;
    lane_nxt          = lane_r;
    rdata_nxt         = rdata_r;
    out_status_nxt    = out_status_r;
    out_read_data_nxt = out_read_data_r;
    out_pa_nxt        = out_pa_r;
    out_bank_nxt      = out_bank_r;
    out_start_nxt     = out_start_r;
    out_hit_nxt       = out_hit_r;
    out_bus_mode_nxt  = out_bus_mode_r;
    rq_push           = 1'b0;
    wq_push           = 1'b0;
    rq_pop            = 1'b0;
    wq_pop            = 1'b0;
    sw                = 1'b0;

    if (cfg_wr_en) begin
      unique case (cfg_index[0])
        CFG_BURST_LIMIT: burst_limit_nxt = cfg_wdata[10:0];
        CFG_BANK_BUSY:   busy_time_nxt   = cfg_wdata;
        default:         burst_limit_nxt = burst_limit_r;
      endcase
    end

    if (rv_r) begin
      rdata_nxt[lane_r*8 +: 8] = buf_q_r;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          out_read_data_nxt = '0;
          out_pa_nxt        = '0;
          out_bank_nxt      = '0;
          out_start_nxt     = '0;
          out_hit_nxt       = 1'b0;
          out_status_nxt    = ST_ENQUEUED;
          if (in_mode == IN_ENQUEUE) begin
            out_valid_nxt    = 1'b1;
            out_bus_mode_nxt = cur_mode_r;
            if (in_address[0]) begin
              if (rq_st.full) out_status_nxt = ST_QUEUE_FULL;
              else            rq_push = 1'b1;
            end else begin
              if (wq_st.full) out_status_nxt = ST_QUEUE_FULL;
              else            wq_push = 1'b1;
            end
          end else if (cur_mode_r == MODE_TURN) begin
            cur_mode_nxt      = prev_mode_r ? MODE_READ : MODE_WRITE;
            reads_served_nxt  = '0;
            writes_served_nxt = '0;
            out_status_nxt    = ST_TRANSITION;
            out_bus_mode_nxt  = cur_mode_nxt;
            out_valid_nxt     = 1'b1;
            step_time_nxt     = step_time_r + 64'd1;
          end else begin
            if (own_empty) begin
              sw             = other_busy;
              out_status_nxt = ST_NO_REQUEST;
              out_valid_nxt  = 1'b1;
              step_time_nxt  = step_time_r + 64'd1;
            end else begin
              sw           = (served_inc >= burst_limit_r) && other_busy;
              serve_rd_nxt = reading;
              state_nxt    = S_TSTART;
              if (reading) begin
                rq_pop           = 1'b1;
                reads_served_nxt = served_inc;
              end else begin
                wq_pop            = 1'b1;
                writes_served_nxt = served_inc;
              end
            end
            if (sw) begin
              prev_mode_nxt = cur_mode_r[0];
              cur_mode_nxt  = MODE_TURN;
            end
            out_bus_mode_nxt = cur_mode_nxt;
          end
        end
      end
      S_TSTART: begin
        addr_nxt  = q_addr;
        wdata_nxt = wq_data[63:0];
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        if (tidx_done) state_nxt = S_TLOOK;
      end
      S_TLOOK: begin
        hit_nxt   = hit_c;
        pa_nxt    = pa_c;
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        if (bank_done && base_done) state_nxt = S_BANKRD;
      end
      S_BANKRD: begin
        step_time_nxt = start_c;
        start_nxt     = start_c;
        buf_idx_nxt   = base_rem;
        byte_cnt_nxt  = '0;
        rdata_nxt     = '0;
        state_nxt     = S_BYTE;
      end
      S_BYTE: begin
        rv_nxt       = serve_rd_r;
        lane_nxt     = byte_cnt_r;
        buf_idx_nxt  = (buf_idx_r == BUF_LAST) ? '0 : buf_idx_r + 1'b1;
        byte_cnt_nxt = byte_cnt_r + 3'd1;
        if (byte_cnt_r == 3'd7) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_status_nxt    = serve_rd_r ? ST_READ_DONE : ST_WRITE_DONE;
        out_read_data_nxt = rdata_r;
        out_pa_nxt        = pa_r;
        out_bank_nxt      = bank_ext[3:0];
        out_start_nxt     = start_r;
        out_hit_nxt       = hit_r;
        out_bus_mode_nxt  = cur_mode_r;
        out_valid_nxt     = 1'b1;
        step_time_nxt     = step_time_r + 64'd1;
        state_nxt         = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      burst_limit_r   <= BURST_RESET;
      busy_time_r     <= BUSY_RESET;
      cur_mode_r      <= MODE_READ;
      prev_mode_r     <= 1'b0;
      reads_served_r  <= '0;
      writes_served_r <= '0;
      step_time_r     <= '0;
      clr_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
      rv_r            <= 1'b0;
      byte_cnt_r      <= '0;
    end else begin
      state_r         <= state_nxt;
      burst_limit_r   <= burst_limit_nxt;
      busy_time_r     <= busy_time_nxt;
      cur_mode_r      <= cur_mode_nxt;
      prev_mode_r     <= prev_mode_nxt;
      reads_served_r  <= reads_served_nxt;
      writes_served_r <= writes_served_nxt;
      step_time_r     <= step_time_nxt;
      clr_cnt_r       <= clr_cnt_nxt;
      out_valid_r     <= out_valid_nxt;
      rv_r            <= rv_nxt;
      byte_cnt_r      <= byte_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    serve_rd_r      <= serve_rd_nxt;
    addr_r          <= addr_nxt;
    wdata_r         <= wdata_nxt;
    hit_r           <= hit_nxt;
    pa_r            <= pa_nxt;
    start_r         <= start_nxt;
    buf_idx_r       <= buf_idx_nxt;
    lane_r          <= lane_nxt;
    rdata_r         <= rdata_nxt;
    out_status_r    <= out_status_nxt;
    out_read_data_r <= out_read_data_nxt;
    out_pa_r        <= out_pa_nxt;
    out_bank_r      <= out_bank_nxt;
    out_start_r     <= out_start_nxt;
    out_hit_r       <= out_hit_nxt;
    out_bus_mode_r  <= out_bus_mode_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_read_data        = out_read_data_r;
  assign out_physical_address = out_pa_r;
  assign out_bank_number      = out_bank_r;
  assign out_start_time       = out_start_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_bus_mode         = out_bus_mode_r;

`ifndef SYNTH
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(rq_st.empty && rq_st.full) && !(wq_st.empty && wq_st.full))
    else $error("queue reports empty and full together");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result presented during clearing pass");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid_r)
    else $error("served transaction produced no result");
`endif

endmodule

// ===== bench/read_write_grouping_memory_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_write_grouping_memory_controller_tb
// Self-checking bench for the read/write grouping controller. A behavioural
// copy of queues, TLB, bank timers and byte buffer predicts every result;
// directed checks cover reset state, mode turnaround, buffer wrap and a full
// queue, then random traffic runs over several register settings and
// idle patterns on both channels.
// ----------------------------------------------------------------------------
module read_write_grouping_memory_controller_tb;
  import rwg_pkg::*;

  localparam int QDEPTH    = 1024;
  localparam int NBANK     = 16;
  localparam int NTLB      = 64;
  localparam int NBYTES    = 65536;
  localparam int DRAIN_CYC = 40;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_data;
    logic [31:0] phys_addr;
    logic [3:0]  bank;
    logic [63:0] start_time;
    logic        tlb_hit;
    logic [1:0]  bus_mode;
  } ctrl_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = IN_ENQUEUE;
  logic [31:0] in_address = '0;
  logic [63:0] in_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [63:0] out_read_data;
  logic [31:0] out_physical_address;
  logic [3:0]  out_bank_number;
  logic [63:0] out_start_time;
  logic        out_tlb_hit;
  logic [1:0]  out_bus_mode;
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_index = CFG_BURST_LIMIT;
  logic [15:0] cfg_wdata = '0;

  read_write_grouping_memory_controller i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_address(in_address), .in_write_data(in_write_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_read_data(out_read_data), .out_physical_address(out_physical_address),
    .out_bank_number(out_bank_number), .out_start_time(out_start_time),
    .out_tlb_hit(out_tlb_hit), .out_bus_mode(out_bus_mode),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow controller state
  logic [10:0] burst_limit;
  logic [15:0] busy_time;
  logic [31:0] rq_addr [QDEPTH];
  logic [31:0] wq_addr [QDEPTH];
  logic [63:0] wq_data [QDEPTH];
  int unsigned rd_head, rd_tail, rd_occ, wr_head, wr_tail, wr_occ;
  logic [1:0]  cur_mode;
  logic [1:0]  prev_mode;
  logic [10:0] reads_served, writes_served;
  logic [31:0] tlb_tag [NTLB];
  logic [31:0] tlb_xlat [NTLB];
  logic [63:0] bank_ready [NBANK];
  logic [63:0] step_time;
  logic [7:0]  buf_bytes [NBYTES];

  ctrl_result_t expected_results [$];
  int          n_errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [31:0] addr_pool [32];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic shadow_reset();
    burst_limit = BURST_RESET;
    busy_time = BUSY_RESET;
    rd_head = 0; rd_tail = 0; rd_occ = 0;
    wr_head = 0; wr_tail = 0; wr_occ = 0;
    cur_mode = MODE_READ;
    prev_mode = MODE_READ;
    reads_served = '0;
    writes_served = '0;
    step_time = '0;
    for (int i = 0; i < NTLB; i++) begin
      tlb_tag[i] = '0;
      tlb_xlat[i] = '0;
    end
    for (int i = 0; i < NBANK; i++) bank_ready[i] = '0;
    for (int i = 0; i < NBYTES; i++) buf_bytes[i] = '0;
  endtask

  task automatic access_buffer(input logic [31:0] addr, input logic [63:0] wdata,
                               inout ctrl_result_t r);
    logic [5:0]  ti;
    logic [31:0] pa;
    logic [3:0]  bank;
    logic [63:0] start;
    logic [15:0] idx;
    ti = addr[5:0];
    r.tlb_hit = (tlb_tag[ti] == addr);
    if (r.tlb_hit) begin
      pa = tlb_xlat[ti];
    end else begin
      pa = addr ^ (addr >> MISS_SHIFT);
      tlb_tag[ti] = addr;
      tlb_xlat[ti] = pa;
    end
    bank = pa[3:0];
    start = (bank_ready[bank] > step_time) ? bank_ready[bank] : step_time;
    step_time = start;
    r.read_data = '0;
    for (int i = 0; i < 8; i++) begin
      idx = pa[15:0] + 16'(i);
      if (addr[0]) r.read_data[8*i +: 8] = buf_bytes[idx];
      else buf_bytes[idx] = wdata[8*i +: 8];
    end
    bank_ready[bank] = start + 64'(busy_time);
    r.status = addr[0] ? ST_READ_DONE : ST_WRITE_DONE;
    r.phys_addr = pa;
    r.bank = bank;
    r.start_time = start;
  endtask

  task automatic predict_controller(input logic mode, input logic [31:0] addr,
                                    input logic [63:0] wdata, output ctrl_result_t r);
    logic turn;
    r = '0;
    turn = 1'b0;
    if (mode == IN_ENQUEUE) begin
      if (addr[0]) begin
        if (rd_occ >= QDEPTH) begin
          r.status = ST_QUEUE_FULL;
        end else begin
          rq_addr[rd_tail] = addr;
          rd_tail = (rd_tail + 1) % QDEPTH;
          rd_occ++;
        end
      end else begin
        if (wr_occ >= QDEPTH) begin
          r.status = ST_QUEUE_FULL;
        end else begin
          wq_addr[wr_tail] = addr;
          wq_data[wr_tail] = wdata;
          wr_tail = (wr_tail + 1) % QDEPTH;
          wr_occ++;
        end
      end
    end else if (cur_mode == MODE_TURN) begin
      cur_mode = (prev_mode == MODE_READ) ? MODE_WRITE : MODE_READ;
      reads_served = '0;
      writes_served = '0;
      r.status = ST_TRANSITION;
    end else if (cur_mode == MODE_READ) begin
      if (rd_occ == 0) begin
        r.status = ST_NO_REQUEST;
        turn = (wr_occ > 0);
      end else begin
        access_buffer(rq_addr[rd_head], '0, r);
        rd_head = (rd_head + 1) % QDEPTH;
        rd_occ--;
        if (reads_served < COUNT_MAX) reads_served++;
        turn = (reads_served >= burst_limit) && (wr_occ > 0);
      end
    end else begin
      if (wr_occ == 0) begin
        r.status = ST_NO_REQUEST;
        turn = (rd_occ > 0);
      end else begin
        access_buffer(wq_addr[wr_head], wq_data[wr_head], r);
        wr_head = (wr_head + 1) % QDEPTH;
        wr_occ--;
        if (writes_served < COUNT_MAX) writes_served++;
        turn = (writes_served >= burst_limit) && (rd_occ > 0);
      end
    end
    if (turn) begin
      prev_mode = cur_mode;
      cur_mode = MODE_TURN;
    end
    if (mode == IN_SERVICE) step_time++;
    r.bus_mode = cur_mode;
  endtask

  task automatic send_item(input logic mode, input logic [31:0] addr,
                           input logic [63:0] wdata);
    ctrl_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_address <= addr;
    in_write_data <= wdata;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_controller(mode, addr, wdata, r);
    expected_results.push_back(r);
  endtask

  task automatic write_register(input logic [0:0] idx, input logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_BURST_LIMIT) burst_limit = value[10:0];
    else busy_time = value;
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    ctrl_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d exp %0d", out_status, e.status));
        if (out_read_data !== e.read_data)
          report_mismatch($sformatf("read_data %h exp %h", out_read_data, e.read_data));
        if (out_physical_address !== e.phys_addr)
          report_mismatch($sformatf("phys %h exp %h", out_physical_address, e.phys_addr));
        if (out_bank_number !== e.bank)
          report_mismatch($sformatf("bank %0d exp %0d", out_bank_number, e.bank));
        if (out_start_time !== e.start_time)
          report_mismatch($sformatf("start %0d exp %0d", out_start_time, e.start_time));
        if (out_tlb_hit !== e.tlb_hit)
          report_mismatch($sformatf("tlb_hit %0b exp %0b", out_tlb_hit, e.tlb_hit));
        if (out_bus_mode !== e.bus_mode)
          report_mismatch($sformatf("bus_mode %0d exp %0d", out_bus_mode, e.bus_mode));
      end
    end
  end

  // empty queue, turnaround, reset TLB hit on address zero, buffer wrap
  task automatic test_directed();
    send_item(IN_SERVICE, '0, '0);
    send_item(IN_ENQUEUE, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(IN_SERVICE, '0, '0);
    send_item(IN_SERVICE, '0, '0);
    send_item(IN_SERVICE, '0, '0);
    send_item(IN_ENQUEUE, 32'h0000_FFF6, 64'h0123_4567_89AB_CDEF);
    send_item(IN_ENQUEUE, 32'h0000_FFF7, '0);
    send_item(IN_ENQUEUE, 32'hFFFF_FFFF, '0);
    send_item(IN_ENQUEUE, 32'hFFFF_FFFE, 64'h0);
    send_item(IN_ENQUEUE, 32'h1, '0);
    for (int i = 0; i < 12; i++) send_item(IN_SERVICE, '0, '0);
  endtask

  task automatic test_queue_full();
    for (int i = 0; i <= QDEPTH; i++)
      send_item(IN_ENQUEUE, {8'($urandom_range(255)), 8'h00, 16'(i)} | 32'h1, '0);
    send_item(IN_ENQUEUE, 32'h0000_0001, '0);
  endtask

  task automatic test_random(input int n_items);
    logic [31:0] a;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 45) begin
        a = ($urandom_range(1)) ? addr_pool[$urandom_range(31)] : $urandom;
        if ($urandom_range(1)) a[0] = ~a[0];
        send_item(IN_ENQUEUE, a, {$urandom, $urandom});
      end else begin
        send_item(IN_SERVICE, $urandom, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 32; i++) addr_pool[i] = $urandom;
    shadow_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 10; recv_idle_pct = 79;
    test_directed();
    test_queue_full();
    write_register(CFG_BURST_LIMIT, 16'd1);
    write_register(CFG_BANK_BUSY, 16'd0);
    test_random(100);
    write_register(CFG_BURST_LIMIT, 16'd0);
    write_register(CFG_BANK_BUSY, 16'd65535);
    test_random(100);

    send_idle_pct = 79; recv_idle_pct = 10;
    write_register(CFG_BURST_LIMIT, 16'd1024);
    write_register(CFG_BANK_BUSY, 16'd100);
    test_random(100);
    write_register(CFG_BURST_LIMIT, 16'd4);
    write_register(CFG_BANK_BUSY, 16'd7);
    test_random(100);

    send_idle_pct = 0; recv_idle_pct = 0;
    write_register(CFG_BURST_LIMIT, 16'd2);
    write_register(CFG_BANK_BUSY, 16'd3);
    test_random(100);

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rwg_pkg.sv
sv/rwg_mod.sv
sv/rwg_queue.sv
sv/read_write_grouping_memory_controller.sv
bench/read_write_grouping_memory_controller_tb.sv
